FILE: hw/rtl/fnp_pkg.sv
// ----------------------------------------------------------------------------
// fnp_pkg
// Shared types, byte constants and the IUPAC code table for the packer.
// ----------------------------------------------------------------------------
package fnp_pkg;

  localparam logic [1:0] MODE_BODY = 2'd0;
  localparam logic [1:0] MODE_COPY = 2'd1;
  localparam logic [1:0] MODE_SKIP = 2'd2;

  localparam logic [7:0] NEWLINE_CHR = 8'h0A;
  localparam logic [7:0] CR_CHR      = 8'h0D;
  localparam logic [7:0] HEADER_CHR  = 8'h3E;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int JOB_MAX    = 3;

  typedef struct packed {
    logic [1:0]             cnt;
    logic [JOB_MAX-1:0][7:0] bytes;
  } job_t;

  function automatic logic [3:0] iupac_code(input logic [7:0] b);
    logic [3:0] c;
    unique case (b)
      8'h41:   c = 4'h8;  // A
      8'h43:   c = 4'h4;  // C
      8'h47:   c = 4'h2;  // G
      8'h54:   c = 4'h1;  // T
      8'h57:   c = 4'h9;  // W
      8'h53:   c = 4'h6;  // S
      8'h4D:   c = 4'hC;  // M
      8'h4B:   c = 4'h3;  // K
      8'h52:   c = 4'hA;  // R
      8'h59:   c = 4'h5;  // Y
      8'h42:   c = 4'h7;  // B
      8'h44:   c = 4'hB;  // D
      8'h48:   c = 4'hD;  // H
      8'h56:   c = 4'hE;  // V
      8'h4E:   c = 4'hF;  // N
      default: c = 4'h0;
    endcase
    return c;
  endfunction

endpackage

FILE: hw/rtl/fasta_nucleotide_nibble_packer.sv
// ----------------------------------------------------------------------------
// fasta_nucleotide_nibble_packer
// Packs FASTA sequence bytes into 4-bit IUPAC codes, two per output byte.
// ----------------------------------------------------------------------------
// Input side is a queue write port: present a file byte (or an end-of-file
// marker) with push; it is taken on a clock edge with push high and full low.
// Result side is a queue read port: while empty is low the oldest result byte
// is on out_byte, with out_last_of_run set on the final byte of its item;
// pop takes it.
// The classifier handles one item per cycle while full is low and files up
// to three result bytes as one job in a four-entry queue; the job is written
// into the queue on the edge that takes its item. The serialiser sends one
// byte per cycle while pop is high, so an item with two or three results
// needs as many pops, and the input side runs on until the job queue fills.
// Items that give no result leave the queue untouched.
// When the receiver stops popping, jobs gather in the queue and full rises
// once it holds four. Reset empties the queue, clears the line state and sets
// keep_headers to 0. cfg_keep_headers is written on any edge with cfg_write_en
// high; the user must write it only while idle, and the block does not check.
// ----------------------------------------------------------------------------
module fasta_nucleotide_nibble_packer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_write_en,
  input  logic       cfg_keep_headers,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_data_byte,
  input  logic       in_end_of_file,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       out_last_of_run
);
  import fnp_pkg::*;

  job_t job, head_job;
  logic job_push, head_done, accept;

  assign accept = push && !full;

  fnp_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_write_en     (cfg_write_en),
    .cfg_keep_headers (cfg_keep_headers),
    .accept           (accept),
    .data_byte        (in_data_byte),
    .end_of_file      (in_end_of_file),
    .job_push         (job_push),
    .job              (job)
  );

  fnp_job_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (job_push),
    .wr_job     (job),
    .rd_en      (head_done),
    .rd_job     (head_job),
    .fifo_full  (full),
    .fifo_empty (empty)
  );

  fnp_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_job        (head_job),
    .head_empty      (empty),
    .pop             (pop),
    .head_done       (head_done),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run)
  );

endmodule

FILE: hw/rtl/fnp_front.sv
// ----------------------------------------------------------------------------
// fnp_front
// Classifies each input byte, updates the line state and builds a job of up
// to three result bytes for the back end.
// ----------------------------------------------------------------------------
module fnp_front (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_write_en,
  input  logic         cfg_keep_headers,
  input  logic         accept,
  input  logic [7:0]   data_byte,
  input  logic         end_of_file,
  output logic         job_push,
  output fnp_pkg::job_t job
);
  import fnp_pkg::*;

  logic       keep_r;
  logic [1:0] mode_r, mode_nxt;
  logic [3:0] held_r, held_nxt;
  logic       nib_wait_r, nib_wait_nxt;
  logic       pend_r, pend_nxt;
  logic       first_r, first_nxt;

  always_comb begin
    logic [1:0] n;
    n            = 2'd0;
    job          = '0;
    mode_nxt     = mode_r;
    held_nxt     = held_r;
    nib_wait_nxt = nib_wait_r;
    pend_nxt     = 1'b0;
    first_nxt    = 1'b0;
    if (end_of_file) begin
      if (mode_r == MODE_COPY) begin
        job.bytes[n] = NEWLINE_CHR;
        n = n + 2'd1;
      end
      job.bytes[n] = NEWLINE_CHR;
      n = n + 2'd1;
      mode_nxt     = MODE_BODY;
      held_nxt     = 4'h0;
      nib_wait_nxt = 1'b0;
      first_nxt    = 1'b1;
    end else if (mode_r == MODE_COPY) begin
      job.bytes[0] = data_byte;
      n = 2'd1;
      if (data_byte == NEWLINE_CHR) mode_nxt = MODE_BODY;
    end else if (mode_r == MODE_SKIP) begin
      if (data_byte == NEWLINE_CHR) mode_nxt = MODE_BODY;
    end else if (data_byte == CR_CHR) begin
      n = 2'd0;
    end else if (data_byte == NEWLINE_CHR) begin
      pend_nxt = 1'b1;
    end else if (data_byte == HEADER_CHR) begin
      if (pend_r && nib_wait_r) begin
        job.bytes[n] = {held_r, 4'h0};
        n = n + 2'd1;
        nib_wait_nxt = 1'b0;
        held_nxt     = 4'h0;
      end
      if (pend_r && keep_r) begin
        job.bytes[n] = NEWLINE_CHR;
        n = n + 2'd1;
      end
      if (keep_r) begin
        job.bytes[n] = HEADER_CHR;
        n = n + 2'd1;
        mode_nxt = MODE_COPY;
      end else begin
        if (!first_r) begin
          job.bytes[n] = NEWLINE_CHR;
          n = n + 2'd1;
        end
        mode_nxt = MODE_SKIP;
      end
    end else if (nib_wait_r) begin
      job.bytes[0] = {held_r, iupac_code(data_byte)};
      n = 2'd1;
      nib_wait_nxt = 1'b0;
      held_nxt     = 4'h0;
    end else begin
      held_nxt     = iupac_code(data_byte);
      nib_wait_nxt = 1'b1;
    end
    job.cnt  = n;
    job_push = accept && (n != 2'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_r     <= 1'b0;
      mode_r     <= MODE_BODY;
      held_r     <= 4'h0;
      nib_wait_r <= 1'b0;
      pend_r     <= 1'b0;
      first_r    <= 1'b1;
    end else begin
      if (cfg_write_en) keep_r <= cfg_keep_headers;
      if (accept) begin
        mode_r     <= mode_nxt;
        held_r     <= held_nxt;
        nib_wait_r <= nib_wait_nxt;
        pend_r     <= pend_nxt;
        first_r    <= first_nxt;
      end
    end
  end

  a_pend_in_body: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (mode_r != MODE_COPY && mode_r != MODE_SKIP))
    else $error("newline pending outside sequence body");

endmodule

FILE: hw/rtl/fnp_job_fifo.sv
// ----------------------------------------------------------------------------
// fnp_job_fifo
// Short queue of jobs between the classifier and the serialiser.
// ----------------------------------------------------------------------------
module fnp_job_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  fnp_pkg::job_t wr_job,
  input  logic          rd_en,
  output fnp_pkg::job_t rd_job,
  output logic          fifo_full,
  output logic          fifo_empty
);
  import fnp_pkg::*;

  job_t               mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]   count_r, count_nxt;
  logic               do_wr, do_rd;

  assign fifo_full  = (count_r == FIFO_AW'(0) + (FIFO_AW+1)'(FIFO_DEPTH));
  assign fifo_empty = (count_r == '0);
  assign do_wr      = wr_en && !fifo_full;
  assign do_rd      = rd_en && !fifo_empty;
  assign rd_job     = mem[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_wr && !do_rd) count_nxt = count_r + (FIFO_AW+1)'(1);
    else if (!do_wr && do_rd) count_nxt = count_r - (FIFO_AW+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr_r] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) wr_ptr_r <= wr_ptr_r + FIFO_AW'(1);
      if (do_rd) rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      count_r <= count_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (FIFO_AW+1)'(FIFO_DEPTH))
    else $error("job queue over-filled");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r[FIFO_AW-1:0] == (wr_ptr_r - rd_ptr_r)))
    else $error("queue pointers disagree with fill count");

endmodule

FILE: hw/rtl/fnp_back.sv
// ----------------------------------------------------------------------------
// fnp_back
// Serialises the head job one byte per request, flagging its final byte.
// ----------------------------------------------------------------------------
module fnp_back (
  input  logic          clk,
  input  logic          rst_n,
  input  fnp_pkg::job_t head_job,
  input  logic          head_empty,
  input  logic          pop,
  output logic          head_done,
  output logic [7:0]    out_byte,
  output logic          out_last_of_run
);
  import fnp_pkg::*;

  logic [1:0] idx_r, idx_nxt;
  logic       take;

  assign out_byte        = head_job.bytes[idx_r];
  assign out_last_of_run = (idx_r == head_job.cnt - 2'd1);
  assign take            = pop && !head_empty;
  assign head_done       = take && out_last_of_run;

  always_comb begin
    idx_nxt = idx_r;
    if (head_done) idx_nxt = 2'd0;
    else if (take) idx_nxt = idx_r + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) idx_r <= 2'd0;
    else        idx_r <= idx_nxt;
  end

  a_idx_in_job: assert property (@(posedge clk) disable iff (!rst_n)
    !head_empty |-> (idx_r < head_job.cnt))
    else $error("serialiser index beyond job length");

  a_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
    head_empty |-> (idx_r == 2'd0))
    else $error("serialiser index held with no job");

endmodule

FILE: tb/sv/fasta_nucleotide_nibble_packer_test.sv
// ----------------------------------------------------------------------------
// fasta_nucleotide_nibble_packer_test
// Drives FASTA bytes and end-of-file requests through the packer, works out
// the packed bytes, header copies and newlines each request should give, and
// compares every popped result field by field, with random gaps on both
// sides and both header settings.
// ----------------------------------------------------------------------------
module fasta_nucleotide_nibble_packer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import fnp_pkg::*;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } packed_byte_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_write_en;
  logic       cfg_keep_headers;
  logic       push;
  logic       full;
  logic [7:0] in_data_byte;
  logic       in_end_of_file;
  logic       empty;
  logic       pop;
  logic [7:0] out_byte;
  logic       out_last_of_run;

  packed_byte_t expected_bytes[$];
  packed_byte_t popped;
  int           errors;
  int           items_sent;
  bit           calm;

  logic       keep_hdr;
  logic [1:0] hdr_state;
  logic [3:0] odd_nibble;
  logic       odd_valid;
  logic       nl_seen;
  logic       file_fresh;

  fasta_nucleotide_nibble_packer dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_write_en    (cfg_write_en),
    .cfg_keep_headers(cfg_keep_headers),
    .push            (push),
    .full            (full),
    .in_data_byte    (in_data_byte),
    .in_end_of_file  (in_end_of_file),
    .empty           (empty),
    .pop             (pop),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic logic [3:0] nibble_of(input logic [7:0] b);
    string      letters;
    logic [3:0] code;
    letters = "-TGKCYSBAWRDMHVN";
    code = 4'h0;
    for (int i = 1; i < 16; i++) begin
      if (letters[i] == b) code = i[3:0];
    end
    return code;
  endfunction

  function automatic void clear_line_state();
    hdr_state  = MODE_BODY;
    odd_nibble = 4'h0;
    odd_valid  = 1'b0;
    nl_seen    = 1'b0;
    file_fresh = 1'b1;
  endfunction

  function automatic void predict_packed_bytes(input logic [7:0] b, input logic eof);
    logic [7:0] outs[$];
    logic       first;
    logic       pend;
    packed_byte_t item;
    if (eof) begin
      if (hdr_state == MODE_COPY) outs.push_back(NEWLINE_CHR);
      outs.push_back(NEWLINE_CHR);
      clear_line_state();
    end else begin
      first = file_fresh;
      pend = nl_seen;
      file_fresh = 1'b0;
      nl_seen = 1'b0;
      if (hdr_state == MODE_COPY) begin
        outs.push_back(b);
        if (b == NEWLINE_CHR) hdr_state = MODE_BODY;
      end else if (hdr_state == MODE_SKIP) begin
        if (b == NEWLINE_CHR) hdr_state = MODE_BODY;
      end else if (b == CR_CHR) begin
      end else if (b == NEWLINE_CHR) begin
        nl_seen = 1'b1;
      end else if (b == HEADER_CHR) begin
        if (pend) begin
          if (odd_valid) begin
            outs.push_back({odd_nibble, 4'h0});
            odd_valid = 1'b0;
            odd_nibble = 4'h0;
          end
          if (keep_hdr) outs.push_back(NEWLINE_CHR);
        end
        if (keep_hdr) begin
          outs.push_back(HEADER_CHR);
          hdr_state = MODE_COPY;
        end else begin
          if (!first) outs.push_back(NEWLINE_CHR);
          hdr_state = MODE_SKIP;
        end
      end else if (odd_valid) begin
        outs.push_back({odd_nibble, nibble_of(b)});
        odd_valid = 1'b0;
        odd_nibble = 4'h0;
      end else begin
        odd_nibble = nibble_of(b);
        odd_valid = 1'b1;
      end
    end
    for (int i = 0; i < outs.size(); i++) begin
      item.value = outs[i];
      item.last = (i == outs.size() - 1);
      expected_bytes.push_back(item);
    end
  endfunction

  always @(posedge clk) begin
    pop <= calm || ($urandom_range(99) >= 10);
  end

  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      if (expected_bytes.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("unexpected result: byte %h last %b", out_byte, out_last_of_run);
        end
      end else begin
        popped = expected_bytes.pop_front();
        if (popped.value !== out_byte || popped.last !== out_last_of_run) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch: expected byte %h last %b, got byte %h last %b",
                     popped.value, popped.last, out_byte, out_last_of_run);
          end
        end
      end
    end
  end

  task automatic send_item(input logic [7:0] b, input logic eof);
    if (!calm && $urandom_range(99) < 10) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_data_byte <= b;
    in_end_of_file <= eof;
    do @(posedge clk); while (full);
    predict_packed_bytes(b, eof);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  task automatic drain_results();
    push <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_keep_headers(input logic v);
    drain_results();
    cfg_write_en <= 1'b1;
    cfg_keep_headers <= v;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    keep_hdr = v;
  endtask

  task automatic test_body_packing();
    set_keep_headers(1'b0);
    send_text("A\r\nN");
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b0);
    send_text("C");
    send_item(8'hFF, 1'b1);
  endtask

  task automatic test_header_copy();
    set_keep_headers(1'b1);
    send_text(">x\r\nT\n>q");
    send_item(8'h00, 1'b1);
  endtask

  task automatic test_header_skip();
    set_keep_headers(1'b0);
    send_text(">z\nG\n\r>\n\n>a\n");
    send_item(8'h5A, 1'b1);
  endtask

  task automatic test_mode_latched_at_header();
    set_keep_headers(1'b1);
    send_text(">h");
    set_keep_headers(1'b0);
    send_text("i\n>j");
    set_keep_headers(1'b1);
    send_text("\nA");
    send_item(8'h00, 1'b1);
  endtask

  task automatic test_random_files();
    string      letters;
    int         start;
    int         phase;
    logic [7:0] b;
    letters = "ACGTWSMKRYBDHVN";
    start = items_sent;
    phase = 0;
    while (items_sent < 290) begin
      set_keep_headers(phase < 2 ? phase[0] : 1'($urandom_range(1)));
      repeat ($urandom_range(1, 3)) begin
        calm = (items_sent - start >= 100) && (items_sent - start < 200);
        if ($urandom_range(99) < 15) begin
          repeat ($urandom_range(1, 20)) begin
            case ($urandom_range(3))
              0:       b = HEADER_CHR;
              1:       b = NEWLINE_CHR;
              default: b = 8'($urandom_range(255));
            endcase
            send_item(b, 1'b0);
          end
        end else begin
          repeat ($urandom_range(1, 3)) begin
            if ($urandom_range(3) != 0) begin
              send_item(HEADER_CHR, 1'b0);
              repeat ($urandom_range(0, 8)) begin
                b = 8'($urandom_range(255));
                send_item(b == NEWLINE_CHR ? CR_CHR : b, 1'b0);
              end
              if ($urandom_range(3) == 0) send_item(CR_CHR, 1'b0);
              send_item(NEWLINE_CHR, 1'b0);
            end
            repeat ($urandom_range(1, 3)) begin
              repeat ($urandom_range(0, 12)) begin
                if ($urandom_range(99) < 5) begin
                  b = 8'($urandom_range(255));
                  send_item(b == NEWLINE_CHR ? 8'h00 : b, 1'b0);
                end else begin
                  send_item(letters[$urandom_range(14)], 1'b0);
                end
              end
              if ($urandom_range(3) == 0) send_item(CR_CHR, 1'b0);
              send_item(NEWLINE_CHR, 1'b0);
            end
          end
        end
        if ($urandom_range(9) != 0) send_item(8'($urandom_range(255)), 1'b1);
      end
      phase++;
    end
    calm = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_write_en = 1'b0;
    cfg_keep_headers = 1'b0;
    push = 1'b0;
    in_data_byte = 8'h00;
    in_end_of_file = 1'b0;
    pop = 1'b0;
    errors = 0;
    items_sent = 0;
    calm = 1'b0;
    keep_hdr = 1'b0;
    clear_line_state();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_body_packing();
    test_header_copy();
    test_header_skip();
    test_mode_latched_at_header();
    test_random_files();

    drain_results();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/fnp_pkg.sv
hw/rtl/fnp_front.sv
hw/rtl/fnp_job_fifo.sv
hw/rtl/fnp_back.sv
hw/rtl/fasta_nucleotide_nibble_packer.sv
tb/sv/fasta_nucleotide_nibble_packer_test.sv
